// ----- src/jse_pkg.sv -----
// Shared types, codes and a helper function for the JSON string escaper.
package jse_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_CHAR = 3'd1;
   localparam logic [2:0] KIND_ESC  = 3'd2;
   localparam logic [2:0] KIND_U16  = 3'd3;
   localparam logic [2:0] KIND_PAIR = 3'd4;

   localparam logic [6:0] CH_QMARK  = 7'h3F;
   localparam logic [6:0] CH_BSLASH = 7'h5C;
   localparam logic [6:0] CH_U      = 7'h75;

   localparam logic [15:0] SURR_HI  = 16'hD800;
   localparam logic [15:0] SURR_LO  = 16'hDC00;
   localparam logic [20:0] SUPP_OFS = 21'h10000;

   typedef struct packed {
      logic [1:0]  qcount;
      logic [2:0]  kind;
      logic [6:0]  ch;
      logic [15:0] hi;
      logic [15:0] lo;
      logic        last;
   } cmd_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] r;
      if (nib < 4'd10) begin
         r = 7'h30 + {3'b000, nib};
      end else begin
         r = 7'h57 + {3'b000, nib};
      end
      return r;
   endfunction

endpackage

// ----- src/jse_front.sv -----
// Front end: accepts input bytes, tracks UTF-8 sequences and builds output commands.
module jse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_in_byte,
   input  logic              req_is_last,
   input  logic              q_full,
   output logic              push,
   output jse_pkg::cmd_type  cmd
);
   import jse_pkg::*;

   logic [1:0]  held_ff, held_in;
   logic [2:0]  exp_ff, exp_in;
   logic [20:0] code_ff, code_in;
   logic        accept;
   logic        fits;
   logic [2:0]  count;
   logic [20:0] acc_shift;
   logic [20:0] v;
   logic [6:0]  esc;
   logic [7:0]  b;

   assign b = req_in_byte;
   assign accept = req_valid && !q_full;

   always_comb begin
      esc = 7'd0;
      case (b)
         8'h22:   esc = 7'h22;
         8'h5C:   esc = 7'h5C;
         8'h0A:   esc = 7'h6E;
         8'h09:   esc = 7'h74;
         8'h0D:   esc = 7'h72;
         8'h08:   esc = 7'h62;
         8'h0C:   esc = 7'h66;
         default: esc = 7'd0;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.last = req_is_last;
      held_in = held_ff;
      exp_in = exp_ff;
      code_in = code_ff;
      count = {1'b0, held_ff} + 3'd1;
      acc_shift = {code_ff[14:0], b[5:0]};
      v = acc_shift - SUPP_OFS;
      fits = (exp_ff == 3'd2) ? b[7] : (b[7:6] == 2'b10);
      if (held_ff != 2'd0 && fits) begin
         if (count >= exp_ff) begin
            if (acc_shift[20:16] == 5'd0) begin
               cmd.kind = KIND_U16;
               cmd.hi = acc_shift[15:0];
            end else begin
               cmd.kind = KIND_PAIR;
               cmd.hi = SURR_HI + {5'd0, v[20:10]};
               cmd.lo = SURR_LO | {6'd0, v[9:0]};
            end
            held_in = 2'd0;
            exp_in = 3'd0;
            code_in = 21'd0;
         end else if (req_is_last) begin
            cmd.qcount = count[1:0];
            held_in = 2'd0;
            exp_in = 3'd0;
            code_in = 21'd0;
         end else begin
            held_in = count[1:0];
            code_in = acc_shift;
         end
      end else begin
         cmd.qcount = held_ff;
         held_in = 2'd0;
         exp_in = 3'd0;
         code_in = 21'd0;
         if (!b[7]) begin
            if (esc != 7'd0) begin
               cmd.kind = KIND_ESC;
               cmd.ch = esc;
            end else if (b < 8'h20) begin
               cmd.kind = KIND_U16;
               cmd.hi = {8'd0, b};
            end else begin
               cmd.kind = KIND_CHAR;
               cmd.ch = b[6:0];
            end
         end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            if (req_is_last) begin
               cmd.kind = KIND_CHAR;
               cmd.ch = CH_QMARK;
            end else begin
               held_in = 2'd1;
               if (b[7:5] == 3'b110) begin
                  exp_in = 3'd2;
                  code_in = {16'd0, b[4:0]};
               end else if (b[7:4] == 4'b1110) begin
                  exp_in = 3'd3;
                  code_in = {17'd0, b[3:0]};
               end else begin
                  exp_in = 3'd4;
                  code_in = {18'd0, b[2:0]};
               end
            end
         end else begin
            cmd.kind = KIND_CHAR;
            cmd.ch = CH_QMARK;
         end
      end
      push = accept && (cmd.qcount != 2'd0 || cmd.kind != KIND_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         exp_ff <= 3'd0;
         code_ff <= 21'd0;
      end else if (accept) begin
         held_ff <= held_in;
         exp_ff <= exp_in;
         code_ff <= code_in;
      end
   end

endmodule

// ----- src/jse_queue.sv -----
// Command queue between the front end and the character sequencer.
module jse_queue #(
   parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jse_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output jse_pkg::cmd_type  head_cmd,
   output logic              head_valid,
   output logic              full
);
   import jse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full = (cnt_ff == FULL_CNT);
   assign head_valid = (cnt_ff != '0);
   assign head_cmd = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

endmodule

// ----- src/jse_back.sv -----
// Back end: expands each queued command into chars, one word per cycle unless stalled.
module jse_back (
   input  logic              clock,
   input  logic              reset,
   input  jse_pkg::cmd_type  head_cmd,
   input  logic              head_valid,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [6:0]        rsp_out_char,
   output logic              rsp_run_last,
   output logic              rsp_string_end
);
   import jse_pkg::*;

   logic [3:0]  idx_ff;
   logic        rsp_valid_ff;
   logic [6:0]  char_ff;
   logic        run_last_ff, string_end_ff;
   logic        load, fire, is_last_char, q_phase, lo_half;
   logic [3:0]  main_len, total, pos, pos_lo;
   logic [2:0]  p6;
   logic [15:0] val;
   logic [3:0]  nib;
   logic [6:0]  ch;

   assign load = !rsp_valid_ff || !rsp_stall;
   assign fire = head_valid && load;

   always_comb begin
      unique case (head_cmd.kind) inside
         KIND_CHAR:            main_len = 4'd1;
         KIND_ESC:             main_len = 4'd2;
         KIND_U16:             main_len = 4'd6;
         KIND_PAIR:            main_len = 4'd12;
         default:              main_len = 4'd0;
      endcase
      total = {2'b00, head_cmd.qcount} + main_len;
      q_phase = idx_ff < {2'b00, head_cmd.qcount};
      pos = idx_ff - {2'b00, head_cmd.qcount};
      lo_half = pos >= 4'd6;
      pos_lo = pos - 4'd6;
      p6 = lo_half ? pos_lo[2:0] : pos[2:0];
      val = lo_half ? head_cmd.lo : head_cmd.hi;
      case (p6)
         3'd2:    nib = val[15:12];
         3'd3:    nib = val[11:8];
         3'd4:    nib = val[7:4];
         default: nib = val[3:0];
      endcase
      if (q_phase) begin
         ch = CH_QMARK;
      end else begin
         unique case (head_cmd.kind) inside
            KIND_ESC: begin
               ch = (pos == 4'd0) ? CH_BSLASH : head_cmd.ch;
            end
            KIND_U16, KIND_PAIR: begin
               if (p6 == 3'd0) begin
                  ch = CH_BSLASH;
               end else if (p6 == 3'd1) begin
                  ch = CH_U;
               end else begin
                  ch = hex_char(nib);
               end
            end
            default: ch = head_cmd.ch;
         endcase
      end
      is_last_char = (idx_ff == total - 4'd1);
      pop = fire && is_last_char;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            idx_ff <= is_last_char ? 4'd0 : idx_ff + 4'd1;
         end
         if (load) begin
            rsp_valid_ff <= head_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         char_ff <= ch;
         run_last_ff <= is_last_char;
         string_end_ff <= is_last_char && head_cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_string_end = string_end_ff;

endmodule

// ----- src/json_string_escaper_core.sv -----
// Top level of the JSON string escaper: front end, command queue and character sequencer.
// With the queue and the output register idle, an accepted byte's command is registered in the
// command queue and its first character then in the output register before it reaches the output.
// Throughput: one byte per cycle unless the queue is full; the sequencer emits one character
// per cycle unless stalled, so a byte of n characters holds it; the queue absorbs the rest.
// Reset is synchronous and clears the sequence state, the queue and the output valid.
module json_string_escaper_core #(
   parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);
   import jse_pkg::*;

   cmd_type push_cmd, head_cmd;
   logic    push, pop, head_valid, q_full;

   assign req_stall = q_full;

   jse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_is_last (req_is_last),
      .q_full      (q_full),
      .push        (push),
      .cmd         (push_cmd)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .full       (q_full)
   );

   jse_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .head_valid     (head_valid),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   a_no_word_from_empty_queue: assert property (@(posedge clock) disable iff (reset)
      (!head_valid && !rsp_valid) |=> !rsp_valid)
      else $error("output word appeared without a queued command");

   a_end_marks_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_end) |-> rsp_run_last)
      else $error("string end flagged on a word that does not close its byte");

   a_pop_only_on_fire: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head_valid && !(rsp_valid && rsp_stall)))
      else $error("command retired while the output register was blocked");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid survived reset");

endmodule
